// ===== hw/rtl/brb_pkg.sv =====
// Shared types and constants of the byte ring buffer.
package brb_pkg;

  // Fixed field widths of the command and result words.
  localparam int unsigned CAP_W  = 13;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned ARG_W  = 12;
  localparam int unsigned CNT_W  = 12;

  // Capacity register value after reset, before clamping to the memory depth.
  localparam int unsigned CAP_RESET = 4096;

  // Operation codes as they arrive on the op field.
  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_DISCARD = 3'd3,
    OP_ADVANCE = 3'd4,
    OP_CLEAR   = 3'd5
  } op_e;

  // Classified command passed from the front end to the execution unit.
  typedef struct packed {
    op_e               op;
    logic              known;
    logic [DATA_W-1:0] data;
    logic [ARG_W-1:0]  arg;
  } cmd_t;

endpackage

// ===== hw/rtl/brb_front.sv =====
// Front end: accepts command words and classifies them for the execution unit.
module brb_front (
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 op_i,
  input  logic [brb_pkg::DATA_W-1:0] data_in_i,
  input  logic [brb_pkg::ARG_W-1:0]  offset_i,
  input  logic [brb_pkg::CNT_W-1:0]  count_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output brb_pkg::cmd_t              q_cmd_o
);
  import brb_pkg::*;

  // Words are taken whenever the command queue has room.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Decode the op code and pick the one argument the operation needs.
  always_comb begin
    q_cmd_o       = '0;
    q_cmd_o.known = (op_i <= OP_CLEAR);
    q_cmd_o.op    = op_e'(op_i);
    q_cmd_o.data  = data_in_i;
    if (q_cmd_o.known && (q_cmd_o.op == OP_PEEK)) begin
      q_cmd_o.arg = offset_i;
    end else begin
      q_cmd_o.arg = ARG_W'(count_i);
    end
  end

endmodule

// ===== hw/rtl/brb_queue.sv =====
// Two-entry command queue between the front end and the execution unit.
module brb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  brb_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output brb_pkg::cmd_t cmd_o
);
  import brb_pkg::*;

  cmd_t       ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = ent_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/brb_back.sv =====
// Execution unit: pointers, space counters, byte memory and result register.
module brb_back #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [brb_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                       cmd_valid_i,
  input  brb_pkg::cmd_t              cmd_i,
  output logic                       cmd_take_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [brb_pkg::DATA_W-1:0] data_out_o,
  output logic                       ok_o,
  output logic [brb_pkg::CNT_W-1:0]  used_o,
  output logic [brb_pkg::CNT_W-1:0]  free_space_o
);
  import brb_pkg::*;

  // Pointer width, capacity width, a width wide enough for sums, the config compare width and the reset capacity.
  localparam int unsigned PW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SW  = ((CW > ARG_W) ? CW : ARG_W) + 1;
  localparam int unsigned FW  = (CAP_W > CW) ? CAP_W : CW;
  localparam int unsigned RST_CAP = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

  logic [CW-1:0]     cap_q, cap_d;
  logic [PW-1:0]     rp_q, rp_d;
  logic [PW-1:0]     wp_q, wp_d;
  logic [PW-1:0]     used_q, used_d;
  logic [PW-1:0]     free_q, free_d;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  logic              out_valid_q;
  logic              ok_q;
  logic              sel_mem_q;
  logic [CNT_W-1:0]  used_res_q;
  logic [CNT_W-1:0]  free_res_q;

  logic              take;
  logic              ok;
  logic              mem_we;
  logic              mem_re;
  logic [PW-1:0]     raddr;
  logic [SW-1:0]     arg_s, used_s, free_s, cap_s;
  logic [SW-1:0]     r_step, r_sum, r_wrap, w_step, w_sum, w_wrap;
  logic [PW-1:0]     r_next, w_next;
  logic [FW-1:0]     cfg_val;
  logic [CW-1:0]     cfg_cap;

  // A new command is executed when the result register is free or drains now.
  assign take       = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_take_o = take;

  assign arg_s  = SW'(cmd_i.arg);
  assign used_s = SW'(used_q);
  assign free_s = SW'(free_q);
  assign cap_s  = SW'(cap_q);

  // Wrapping pointer advance; the step is always below the capacity when used.
  always_comb begin
    r_step = (cmd_i.op == OP_POP) ? SW'(1) : arg_s;
    w_step = (cmd_i.op == OP_PUSH) ? SW'(1) : arg_s;
    r_sum  = SW'(rp_q) + r_step;
    w_sum  = SW'(wp_q) + w_step;
    r_wrap = r_sum - cap_s;
    w_wrap = w_sum - cap_s;
    r_next = (r_sum >= cap_s) ? PW'(r_wrap) : PW'(r_sum);
    w_next = (w_sum >= cap_s) ? PW'(w_wrap) : PW'(w_sum);
  end

  // Clamp a written capacity into the range the memory supports.
  always_comb begin
    cfg_val = FW'(cfg_wdata_i);
    if (cfg_val < FW'(2)) begin
      cfg_cap = CW'(2);
    end else if (cfg_val > FW'(DEPTH)) begin
      cfg_cap = CW'(DEPTH);
    end else begin
      cfg_cap = CW'(cfg_val);
    end
  end

  // Operation decode and next state.
  always_comb begin
    cap_d  = cap_q;
    rp_d   = rp_q;
    wp_d   = wp_q;
    used_d = used_q;
    free_d = free_q;
    ok     = 1'b0;
    mem_we = 1'b0;
    mem_re = 1'b0;
    raddr  = rp_q;
    if (cfg_we_i) begin
      cap_d  = cfg_cap;
      rp_d   = '0;
      wp_d   = '0;
      used_d = '0;
      free_d = PW'(cfg_cap - CW'(1));
    end else if (take && cmd_i.known) begin
      case (cmd_i.op)
        OP_PUSH: begin
          ok = (free_q != '0);
          if (ok) begin
            mem_we = 1'b1;
            wp_d   = w_next;
            used_d = used_q + PW'(1);
            free_d = free_q - PW'(1);
          end
        end
        OP_POP: begin
          ok = (used_q != '0);
          if (ok) begin
            mem_re = 1'b1;
            rp_d   = r_next;
            used_d = used_q - PW'(1);
            free_d = free_q + PW'(1);
          end
        end
        OP_PEEK: begin
          ok = (arg_s < used_s);
          if (ok) begin
            mem_re = 1'b1;
            raddr  = r_next;
          end
        end
        OP_DISCARD: begin
          ok = (arg_s <= used_s);
          if (ok) begin
            rp_d   = r_next;
            used_d = PW'(used_s - arg_s);
            free_d = PW'(free_s + arg_s);
          end
        end
        OP_ADVANCE: begin
          ok = (arg_s <= free_s);
          if (ok) begin
            wp_d   = w_next;
            used_d = PW'(used_s + arg_s);
            free_d = PW'(free_s - arg_s);
          end
        end
        OP_CLEAR: begin
          ok     = 1'b1;
          rp_d   = '0;
          wp_d   = '0;
          used_d = '0;
          free_d = PW'(cap_s - SW'(1));
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  // Pointer, capacity and space registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CW'(RST_CAP);
      rp_q   <= '0;
      wp_q   <= '0;
      used_q <= '0;
      free_q <= PW'(RST_CAP - 1);
    end else begin
      cap_q  <= cap_d;
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      used_q <= used_d;
      free_q <= free_d;
    end
  end

  // Byte memory with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= cmd_i.data;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; the read byte arrives in the memory's read register.
  always_ff @(posedge clk_i) begin
    if (take) begin
      ok_q       <= ok;
      sel_mem_q  <= mem_re;
      used_res_q <= CNT_W'(used_d);
      free_res_q <= CNT_W'(free_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = sel_mem_q ? rdata_q : '0;
  assign ok_o         = ok_q;
  assign used_o       = used_res_q;
  assign free_space_o = free_res_q;

`ifndef NO_ASSERTIONS
  // Used and free space always add up to one less than the capacity.
  a_space_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(used_q) + SW'(free_q) + SW'(1)) == cap_s)
    else $error("used plus free does not match capacity");

  // Both pointers stay below the capacity.
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(rp_q) < cap_s) && (SW'(wp_q) < cap_s))
    else $error("pointer beyond capacity");

  // A pop on an empty queue yields a refused result.
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !cfg_we_i && cmd_i.known && (cmd_i.op == OP_POP) && (used_q == '0))
      |=> (out_valid_o && !ok_o && (used_o == '0)))
    else $error("pop on empty queue not refused");
`endif

endmodule

// ===== hw/rtl/byte_ring_buffer.sv =====
// Byte ring buffer: accepts one word per cycle while the result output is not stalled.
// An accepted word is written into the command queue; the execution unit takes it from
// there and its result is held in the result register.
// A two-entry command queue lets intake continue while a result waits to be taken.
// Reset: pointers and used count clear, capacity returns to 4096 clamped to DEPTH.
module byte_ring_buffer #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [brb_pkg::CAP_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 op_i,
  input  logic [brb_pkg::DATA_W-1:0] data_in_i,
  input  logic [brb_pkg::ARG_W-1:0]  offset_i,
  input  logic [brb_pkg::CNT_W-1:0]  count_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [brb_pkg::DATA_W-1:0] data_out_o,
  output logic                       ok_o,
  output logic [brb_pkg::CNT_W-1:0]  used_o,
  output logic [brb_pkg::CNT_W-1:0]  free_space_o
);
  import brb_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd_in;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd_out;

  // Intake and classification.
  brb_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .data_in_i  (data_in_i),
    .offset_i   (offset_i),
    .count_i    (count_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd_in)
  );

  // Decoupling queue.
  brb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd_out)
  );

  // Execution and result register.
  brb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd_out),
    .cmd_take_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .ok_o         (ok_o),
    .used_o       (used_o),
    .free_space_o (free_space_o)
  );

endmodule
